@@ rtl/core/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Types, constants and helpers for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int IN_W          = 32;
  localparam int NUM_W         = 64;
  localparam int DEN_W         = 62;
  localparam int PROD_W        = 2 * OPERAND_WIDTH;
  localparam int SHIFT_W       = 7;
  localparam int CNT_W         = 6;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_NEG,
    S_NORM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FINISH
  } state_t;

  function automatic logic [OPERAND_WIDTH-1:0] take_mag(input logic [IN_W-1:0] raw);
    logic [OPERAND_WIDTH-1:0] v;
    v = raw[OPERAND_WIDTH-1:0];
    return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

@@ rtl/core/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// One word in, one word out. The operands are cross-multiplied on one shared
// multiplier in S_MUL0, S_MUL1 and S_MUL2; for add and subtract the products
// are combined on one shared 65-bit adder/subtractor. The result is then
// reduced by a binary GCD (each step shifts, subtracts or swaps) and two
// 64-step restoring divisions on the same subtractor. A zero result skips the
// GCD and the divisions. in_ready is low from accept until the unit is back in
// S_IDLE. A finished result waits in the output register, so the next word can
// start at once.
module rational_arithmetic_unit (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [1:0]                                action,
  input  logic signed [rau_pkg::IN_W-1:0]           a_num,
  input  logic signed [rau_pkg::IN_W-1:0]           a_den,
  input  logic signed [rau_pkg::IN_W-1:0]           b_num,
  input  logic signed [rau_pkg::IN_W-1:0]           b_den,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]          res_num,
  output logic [rau_pkg::DEN_W-1:0]                 res_den
);

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int W  = rau_pkg::NUM_W;

  rau_pkg::state_t  state, state_next;
  rau_pkg::action_t act;

  logic [OW-1:0] an, ad, bn, bd;
  logic          an_neg, bn_neg;

  logic [W-1:0]  nm, dm, x, y, dvs, rem;
  logic          nneg, dneg;
  logic [rau_pkg::SHIFT_W-1:0] k;
  logic [rau_pkg::CNT_W-1:0]   cnt;

  // operand normalization at accept
  logic [OW-1:0] m_an, m_ad, m_bn, m_bd;
  logic          za, zb;
  assign m_an = rau_pkg::take_mag(a_num);
  assign m_ad = rau_pkg::take_mag(a_den);
  assign m_bn = rau_pkg::take_mag(b_num);
  assign m_bd = rau_pkg::take_mag(b_den);
  assign za   = (m_an == '0) || (m_ad == '0);
  assign zb   = (m_bn == '0) || (m_bd == '0);

  // shared multiplier
  logic [OW-1:0]     mx, my;
  logic [W-1:0]      prod;
  // shared adder / subtractor
  logic [W:0]        ua, ub;
  logic              usub;
  logic [W+1:0]      ures;
  logic              ucarry;

  assign prod   = W'({{OW{1'b0}}, mx} * {{OW{1'b0}}, my});
  assign ures   = {1'b0, ua} + {1'b0, ub ^ {(W+1){usub}}} + {{(W+1){1'b0}}, usub};
  assign ucarry = ures[W+1];

  logic          sign_b;
  logic [W-1:0]  rem2;
  logic          num_sat, den_sat;
  logic [W-1:0]  num_mag;

  assign sign_b  = bn_neg ^ (act == rau_pkg::ACT_SUB);
  assign rem2    = {rem[W-2:0], 1'b0};
  assign num_sat = nm[W-1];
  assign den_sat = dm[W-1:rau_pkg::DEN_W] != '0;
  assign num_mag = num_sat ? {1'b0, {(W-1){1'b1}}} : nm;

  assign in_ready = (state == rau_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::S_IDLE:   if (in_valid) state_next = rau_pkg::S_MUL0;
      rau_pkg::S_MUL0:   state_next = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:   state_next = rau_pkg::S_MUL2;
      rau_pkg::S_MUL2: begin
        if (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) state_next = rau_pkg::S_ADD;
        else state_next = rau_pkg::S_NORM;
      end
      rau_pkg::S_ADD: begin
        if ((nneg != sign_b) && !ucarry) state_next = rau_pkg::S_NEG;
        else state_next = rau_pkg::S_NORM;
      end
      rau_pkg::S_NEG:    state_next = rau_pkg::S_NORM;
      rau_pkg::S_NORM: begin
        if (nm == '0 || dm == '0) state_next = rau_pkg::S_FINISH;
        else state_next = rau_pkg::S_GCD;
      end
      rau_pkg::S_GCD:    if (x == '0 || y == '0) state_next = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN:   if (cnt == '1) state_next = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD:   if (cnt == '1) state_next = rau_pkg::S_FINISH;
      rau_pkg::S_FINISH: if (!out_valid || out_ready) state_next = rau_pkg::S_IDLE;
      default:           state_next = rau_pkg::S_IDLE;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    mx   = an;
    my   = bd;
    ua   = '0;
    ub   = '0;
    usub = 1'b1;
    case (state)
      rau_pkg::S_MUL0: begin
        mx = an;
        my = (act == rau_pkg::ACT_MUL) ? bn : bd;
      end
      rau_pkg::S_MUL1: begin
        mx = bn;
        my = ad;
      end
      rau_pkg::S_MUL2: begin
        mx = ad;
        my = (act == rau_pkg::ACT_DIV) ? bn : bd;
      end
      rau_pkg::S_ADD: begin
        ua   = {1'b0, nm};
        ub   = {1'b0, x};
        usub = (nneg != sign_b);
      end
      rau_pkg::S_NEG: begin
        ua = '0;
        ub = {1'b0, nm};
      end
      rau_pkg::S_GCD: begin
        ua = {1'b0, x};
        ub = {1'b0, y};
      end
      rau_pkg::S_DIVN: begin
        ua = {rem, nm[W-1]};
        ub = {1'b0, dvs};
      end
      rau_pkg::S_DIVD: begin
        ua = {rem, dm[W-1]};
        ub = {1'b0, dvs};
      end
      rau_pkg::S_FINISH: begin
        ua = '0;
        ub = {1'b0, num_mag};
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rau_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rau_pkg::S_FINISH && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        rau_pkg::S_IDLE: begin
          if (in_valid) begin
            act    <= rau_pkg::action_t'(action);
            an     <= za ? '0 : m_an;
            ad     <= za ? OW'(1) : m_ad;
            an_neg <= !za && (a_num[OW-1] ^ a_den[OW-1]);
            bn     <= zb ? '0 : m_bn;
            bd     <= zb ? OW'(1) : m_bd;
            bn_neg <= !zb && (b_num[OW-1] ^ b_den[OW-1]);
          end
        end
        rau_pkg::S_MUL0: begin
          nm   <= prod;
          nneg <= an_neg ^ ((act == rau_pkg::ACT_MUL) && bn_neg);
        end
        rau_pkg::S_MUL1: x <= prod;
        rau_pkg::S_MUL2: begin
          dm   <= prod;
          dneg <= (act == rau_pkg::ACT_DIV) && bn_neg;
        end
        rau_pkg::S_ADD: begin
          nm <= ures[W-1:0];
          if ((nneg != sign_b) && !ucarry) nneg <= sign_b;
        end
        rau_pkg::S_NEG: nm <= ures[W-1:0];
        rau_pkg::S_NORM: begin
          nneg <= (nm == '0 || dm == '0) ? 1'b0 : (nneg ^ dneg);
          x    <= nm;
          y    <= dm;
          k    <= '0;
          if (nm == '0 || dm == '0) begin
            nm   <= '0;
            dm   <= W'(1);
          end
        end
        rau_pkg::S_GCD: begin
          if (x == '0 || y == '0) begin
            dvs <= x | y;
            nm  <= nm >> k;
            dm  <= dm >> k;
            rem <= '0;
            cnt <= '0;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (ucarry) begin
            x <= ures[W:1];
          end else begin
            x <= y;
            y <= x;
          end
        end
        rau_pkg::S_DIVN: begin
          cnt <= cnt + 1'b1;
          rem <= (cnt == '1) ? '0 :
                 (ucarry ? ures[W-1:0] : (rem2 | {{(W-1){1'b0}}, nm[W-1]}));
          nm  <= {nm[W-2:0], ucarry};
        end
        rau_pkg::S_DIVD: begin
          cnt <= cnt + 1'b1;
          rem <= ucarry ? ures[W-1:0] : (rem2 | {{(W-1){1'b0}}, dm[W-1]});
          dm  <= {dm[W-2:0], ucarry};
        end
        rau_pkg::S_FINISH: begin
          if (!out_valid || out_ready) begin
            res_num   <= nneg ? ures[W-1:0] : num_mag;
            res_den   <= den_sat ? {rau_pkg::DEN_W{1'b1}} : dm[rau_pkg::DEN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_den != '0)
    else $error("result denominator is zero");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == rau_pkg::S_DIVN || state == rau_pkg::S_DIVD) |-> dvs != '0)
    else $error("divisor is zero during reduction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while a word is in work");
`endif

endmodule

@@ test/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Self-checking bench for the rational arithmetic unit.
// ----------------------------------------------------------------------------
// Directed fractions (zero parts, negative denominators, most negative values,
// division by zero, overflow saturation) and ~1400 random words go through a
// bursty driver. A scoreboard predicts each reduced fraction with sign and
// magnitude arithmetic. The receiver stalls randomly and once holds off for a long
// stretch so the input side backs up.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;

  typedef struct {
    rau_pkg::action_t act;
    logic [31:0] an, ad, bn, bd;
  } frac_word_t;

  typedef struct {
    logic [63:0] num;
    logic [61:0] den;
  } frac_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = '0;
  logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [63:0] res_num;
  logic [61:0]       res_den;

  frac_word_t pending_q[$];
  frac_res_t  expected_q[$];
  int         taken_cnt = 0;
  int         issued_cnt = 0;
  int         total_words = 0;
  int         err_cnt = 0;

  rational_arithmetic_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den)
  );

  always #4 clk = ~clk;

  function automatic void to_sm(input logic [31:0] v, output bit s, output logic [63:0] m);
    s = v[31];
    m = s ? {32'b0, (~v + 32'd1)} : {32'b0, v};
    if (m == 0) s = 1'b0;
  endfunction

  function automatic void sm_add(input bit xs, input logic [63:0] xm, input bit ys,
                                 input logic [63:0] ym, output bit rs,
                                 output logic [63:0] rm);
    if (xs == ys) begin
      rs = xs; rm = xm + ym;
    end else if (xm >= ym) begin
      rs = xs; rm = xm - ym;
    end else begin
      rs = ys; rm = ym - xm;
    end
    if (rm == 0) rs = 1'b0;
  endfunction

  function automatic frac_res_t reduce_frac(frac_word_t w);
    bit an_s, ad_s, bn_s, bd_s, ns, ds, p_s, q_s;
    logic [63:0] an_m, ad_m, bn_m, bd_m, nm, dm, p_m, q_m, x, y, t;
    frac_res_t r;
    to_sm(w.an, an_s, an_m);
    to_sm(w.ad, ad_s, ad_m);
    to_sm(w.bn, bn_s, bn_m);
    to_sm(w.bd, bd_s, bd_m);
    if (an_m == 0 || ad_m == 0) begin
      an_s = 0; an_m = 0; ad_s = 0; ad_m = 1;
    end else begin
      an_s = an_s ^ ad_s; ad_s = 0;
    end
    if (bn_m == 0 || bd_m == 0) begin
      bn_s = 0; bn_m = 0; bd_s = 0; bd_m = 1;
    end else begin
      bn_s = bn_s ^ bd_s; bd_s = 0;
    end
    case (w.act)
      rau_pkg::ACT_ADD, rau_pkg::ACT_SUB: begin
        if (w.act == rau_pkg::ACT_SUB) bn_s = !bn_s && bn_m != 0;
        p_m = an_m * bd_m; p_s = an_s && p_m != 0;
        q_m = bn_m * ad_m; q_s = bn_s && q_m != 0;
        sm_add(p_s, p_m, q_s, q_m, ns, nm);
        dm = ad_m * bd_m; ds = 0;
      end
      rau_pkg::ACT_MUL: begin
        nm = an_m * bn_m; ns = (an_s != bn_s) && nm != 0;
        dm = ad_m * bd_m; ds = 0;
      end
      default: begin
        nm = an_m * bd_m; ns = an_s && nm != 0;
        dm = ad_m * bn_m; ds = bn_s && dm != 0;
      end
    endcase
    if (nm == 0 || dm == 0) begin
      ns = 0; nm = 0; dm = 1;
    end else begin
      ns = ns ^ ds;
    end
    if (nm != 0) begin
      x = nm; y = dm;
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      nm = nm / x; dm = dm / x;
    end
    if (nm > 64'h7FFF_FFFF_FFFF_FFFF) nm = 64'h7FFF_FFFF_FFFF_FFFF;
    if (dm > 64'h3FFF_FFFF_FFFF_FFFF) dm = 64'h3FFF_FFFF_FFFF_FFFF;
    r.num = ns ? (~nm + 64'd1) : nm;
    r.den = dm[61:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0001;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      5, 6: return 32'($signed($urandom_range(0, 2000)) - 1000) * 32'($urandom_range(1, 64));
      default: return $urandom;
    endcase
  endfunction

  task automatic add_word(rau_pkg::action_t act, logic [31:0] an, ad, bn, bd);
    frac_word_t w;
    w.act = act; w.an = an; w.ad = ad; w.bn = bn; w.bd = bd;
    pending_q.push_back(w);
    total_words++;
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    frac_word_t w;
    bit nv;
    if (!rst && !(in_valid && taken_cnt != issued_cnt)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        w = pending_q.pop_front();
        action <= w.act;
        a_num <= w.an; a_den <= w.ad; b_num <= w.bn; b_den <= w.bd;
        issued_cnt++;
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
        end
      end
      in_valid <= nv;
    end
  end

  // input acceptance -> prediction
  always @(posedge clk) begin
    frac_word_t w;
    if (!rst && in_valid && in_ready) begin
      w.act = rau_pkg::action_t'(action);
      w.an = a_num; w.ad = a_den; w.bn = b_num; w.bd = b_den;
      expected_q.push_back(reduce_frac(w));
      taken_cnt++;
    end
  end

  // receiver stall pattern plus one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && taken_cnt >= 200) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 2000);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word num=%0d den=%0d", res_num, res_den);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (res_num !== e.num) begin
          $error("res_num expected %0d got %0d", $signed(e.num), res_num);
          err_cnt++;
        end
        if (res_den !== e.den) begin
          $error("res_den expected %0d got %0d", e.den, res_den);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("[rational_arithmetic_unit] ERROR");
    $finish;
  end

  initial begin
    int i;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    add_word(rau_pkg::ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    add_word(rau_pkg::ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
    add_word(rau_pkg::ACT_MUL, 32'd4, 32'd6, 32'd3, 32'd2);
    add_word(rau_pkg::ACT_DIV, 32'd4, 32'd6, 32'd3, 32'd2);
    add_word(rau_pkg::ACT_ADD, 32'd0, 32'd5, 32'd2, 32'd4);
    add_word(rau_pkg::ACT_MUL, 32'd7, 32'd0, 32'd2, 32'd9);
    add_word(rau_pkg::ACT_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
    add_word(rau_pkg::ACT_DIV, 32'd3, 32'd4, 32'd5, 32'd0);
    add_word(rau_pkg::ACT_SUB, 32'd3, -32'sd4, 32'd3, -32'sd4);
    add_word(rau_pkg::ACT_ADD, -32'sd3, -32'sd9, 32'd1, -32'sd6);
    add_word(rau_pkg::ACT_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    add_word(rau_pkg::ACT_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
    add_word(rau_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000);
    add_word(rau_pkg::ACT_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1);
    add_word(rau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
             32'h7FFF_FFFF);
    add_word(rau_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    add_word(rau_pkg::ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000);
    add_word(rau_pkg::ACT_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    add_word(rau_pkg::ACT_DIV, 32'h8000_0000, 32'd3, 32'd1, 32'h8000_0000);
    add_word(rau_pkg::ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    for (i = 0; i < 1400; i++) begin
      add_word(rau_pkg::action_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
               rand_operand(), rand_operand());
    end

    wait (pending_q.size() == 0 && taken_cnt == total_words);
    wait (expected_q.size() == 0);
    repeat (400) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("[rational_arithmetic_unit] OK");
    end else begin
      $display("[rational_arithmetic_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/rau_pkg.sv
rtl/core/rational_arithmetic_unit.sv
test/tb_rational_arithmetic_unit.sv
